// ===== sv/csmp_pkg.sv =====
// Shared types and constants for the compound shape mass properties block.
// Depends on nothing; read first.
package csmp_pkg;

    localparam int FRAC_BITS = 16;

    // radix-4 serial multiplier over a 32-bit multiplier operand
    localparam int MUL_STEPS = 16;
    // radix-2 restoring divider, one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // full product of a 65-bit sum of squares and a 32-bit weight
    localparam int PROD_W = 97;
    localparam int RND_W  = (2 * FRAC_BITS + 65 > PROD_W) ? 2 * FRAC_BITS + 65 : PROD_W;
    localparam logic [RND_W-1:0] RND_HALF = {{(RND_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);

    localparam logic [2:0] SHAPE_PLANE = 3'd3;

    localparam logic [2:0] BODY_NOTHING = 3'd0;
    localparam logic [2:0] BODY_POLYGON = 3'd1;
    localparam logic [2:0] BODY_RECT    = 3'd2;
    localparam logic [2:0] BODY_UNKNOWN = 3'd5;

    typedef struct packed {
        logic [2:0]         shape_kind;
        logic signed [31:0] part_center_x;
        logic signed [31:0] part_center_y;
        logic [31:0]        part_area;
        logic [63:0]        part_inertia;
        logic               last_part;
    } part_t;

    typedef struct packed {
        logic [2:0]         body_kind;
        logic signed [31:0] body_center_x;
        logic signed [31:0] body_center_y;
        logic [31:0]        body_area;
        logic [63:0]        body_inertia;
        logic               part_dropped;
        logic               last_result;
    } body_t;

endpackage

// ===== sv/csmp_if.sv =====
// Valid/ready channels carrying part items in and body items out.
// Depends on csmp_pkg.
interface csmp_part_if import csmp_pkg::*; ();
    logic  valid;
    logic  ready;
    part_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface csmp_body_if import csmp_pkg::*; ();
    logic  valid;
    logic  ready;
    body_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/compound_shape_mass_properties.sv =====
// Part with area: accepted, then eight radix-4 serial products and two radix-2
// quotients run before a valid body item is written; the next part can be taken in
// the cycle it turns valid. Plane or dropped part: no arithmetic, straight to output.
// The body item sits in an output register, so a new part is taken while it waits.
// rst_n (asynchronous, active low) clears the running totals and empties the output.
// Depends on csmp_pkg and csmp_if.
module compound_shape_mass_properties
    import csmp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    csmp_part_if.sink   part,
    csmp_body_if.source body
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LD_DX,
        ST_RND_X,
        ST_LD_DY,
        ST_RND_Y,
        ST_SQ_X,
        ST_SUM_W1,
        ST_TERM1,
        ST_ADD_T1,
        ST_ADD_PI,
        ST_SQ_EX,
        ST_SUM_W2,
        ST_TERM2,
        ST_ADD_T2,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [2:0]         kind_reg;
    logic [31:0]        cx_reg;
    logic [31:0]        cy_reg;
    logic [31:0]        area_reg;
    logic [63:0]        inertia_reg;

    logic [31:0]        px_reg;
    logic [31:0]        py_reg;
    logic [31:0]        pa_reg;
    logic [63:0]        pi_reg;
    logic               last_reg;
    logic               dropped_reg;

    logic [32:0]        sum_reg;
    logic               neg_x_reg;
    logic               neg_y_reg;
    logic [31:0]        qx_reg;
    logic [31:0]        qy_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        term_reg;

    logic [64:0]        a_reg;
    logic [66:0]        a3_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        qd_reg;

    body_t              out_reg;
    logic               out_valid_reg;

    part_t              in_item;
    logic [2:0]         in_code;
    logic [32:0]        in_dx;

    logic [66:0]        mul_pp;
    logic [66:0]        mul_sum;
    logic [PROD_W-1:0]  p_next;

    logic [33:0]        div_trial;
    logic [33:0]        div_diff;
    logic               div_ge;
    logic [32:0]        rem_next;
    logic [31:0]        qd_next;
    logic               rnd_up;
    logic [31:0]        q_round;

    logic [RND_W-1:0]   prod_rnd;
    logic [63:0]        term_next;
    logic [64:0]        sq_sum;
    logic [32:0]        dy_cur;
    logic [32:0]        ex_cur;
    logic [32:0]        ey_cur;

    function automatic logic [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [31:0] mag32(input logic [32:0] v);
        logic [32:0] n;
        n = v[32] ? (33'd0 - v) : v;
        return n[31:0];
    endfunction

    function automatic logic [31:0] step_coord(input logic [31:0] c, input logic [31:0] q,
                                               input logic neg);
        return neg ? (c - q) : (c + q);
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [2:0] merge_kind(input logic [2:0] acc, input logic [2:0] code);
        logic [2:0] res;
        res = BODY_UNKNOWN;
        if (code == BODY_POLYGON)
        begin
            if (acc == BODY_NOTHING || acc == BODY_POLYGON || acc == BODY_RECT)
                res = BODY_POLYGON;
        end
        else if (code == BODY_RECT)
        begin
            if (acc == BODY_NOTHING)
                res = BODY_RECT;
            else if (acc == BODY_POLYGON || acc == BODY_RECT)
                res = acc;
        end
        else
        begin
            if (acc == BODY_NOTHING || acc == code)
                res = code;
        end
        return res;
    endfunction

    assign in_item = part.payload;
    assign in_code = {1'b0, in_item.shape_kind[1:0]} + 3'd1;
    assign in_dx   = diff33(in_item.part_center_x, cx_reg);

    // radix-4 shift-add step
    always_comb
    begin
        case (p_reg[1:0])
            2'd0:    mul_pp = '0;
            2'd1:    mul_pp = {2'b00, a_reg};
            2'd2:    mul_pp = {1'b0, a_reg, 1'b0};
            default: mul_pp = a3_reg;
        endcase
    end

    assign mul_sum = {2'b00, p_reg[PROD_W-1:32]} + mul_pp;
    assign p_next  = {mul_sum, p_reg[31:2]};

    // restoring divide step and final rounding, ties away from zero
    assign div_trial = {rem_reg, qd_reg[31]};
    assign div_diff  = div_trial - {1'b0, sum_reg};
    assign div_ge    = div_trial >= {1'b0, sum_reg};
    assign rem_next  = div_ge ? div_diff[32:0] : div_trial[32:0];
    assign qd_next   = {qd_reg[30:0], div_ge};
    assign rnd_up    = {rem_reg, 1'b0} >= {1'b0, sum_reg};
    assign q_round   = (sum_reg == '0) ? '0 : qd_reg + {31'd0, rnd_up};

    assign prod_rnd  = RND_W'(p_reg) + RND_HALF;
    assign term_next = (|prod_rnd[RND_W-1:2*FRAC_BITS+64]) ? {64{1'b1}}
                                                           : prod_rnd[2*FRAC_BITS+63:2*FRAC_BITS];
    assign sq_sum    = {1'b0, sq_reg} + {1'b0, p_reg[63:0]};

    assign dy_cur = diff33(py_reg, cy_reg);
    assign ex_cur = diff33(px_reg, cx_reg);
    assign ey_cur = diff33(py_reg, cy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            kind_reg      <= BODY_NOTHING;
            cx_reg        <= '0;
            cy_reg        <= '0;
            area_reg      <= '0;
            inertia_reg   <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            pa_reg        <= '0;
            pi_reg        <= '0;
            last_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            sum_reg       <= '0;
            neg_x_reg     <= 1'b0;
            neg_y_reg     <= 1'b0;
            qx_reg        <= '0;
            qy_reg        <= '0;
            sq_reg        <= '0;
            term_reg      <= '0;
            a_reg         <= '0;
            a3_reg        <= '0;
            p_reg         <= '0;
            rem_reg       <= '0;
            qd_reg        <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && body.ready && state_reg != ST_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (part.valid)
                    begin
                        px_reg      <= in_item.part_center_x;
                        py_reg      <= in_item.part_center_y;
                        pa_reg      <= in_item.part_area;
                        pi_reg      <= in_item.part_inertia;
                        last_reg    <= in_item.last_part;
                        dropped_reg <= in_item.shape_kind[2];
                        // kinds with the top bit set are invalid
                        if (!in_item.shape_kind[2])
                            kind_reg <= merge_kind(kind_reg, in_code);
                        if (in_item.shape_kind[2] || in_item.shape_kind == SHAPE_PLANE)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            sum_reg   <= {1'b0, area_reg} + {1'b0, in_item.part_area};
                            neg_x_reg <= in_dx[32];
                            a_reg     <= {33'd0, mag32(in_dx)};
                            p_reg     <= PROD_W'(in_item.part_area);
                            cnt_reg   <= '0;
                            ret_reg   <= ST_LD_DX;
                            state_reg <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    if (cnt_reg == '0)
                        a3_reg <= {2'b00, a_reg} + {1'b0, a_reg, 1'b0};
                    else
                        p_reg <= p_next;
                    if (cnt_reg == CNT_W'(MUL_STEPS))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    qd_reg  <= qd_next;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_LD_DX:
                begin
                    rem_reg   <= {1'b0, p_reg[63:32]};
                    qd_reg    <= p_reg[31:0];
                    cnt_reg   <= '0;
                    ret_reg   <= ST_RND_X;
                    state_reg <= ST_DIV;
                end

                ST_RND_X:
                begin
                    qx_reg    <= q_round;
                    neg_y_reg <= dy_cur[32];
                    a_reg     <= {33'd0, mag32(dy_cur)};
                    p_reg     <= PROD_W'(pa_reg);
                    cnt_reg   <= '0;
                    ret_reg   <= ST_LD_DY;
                    state_reg <= ST_MUL;
                end

                ST_LD_DY:
                begin
                    rem_reg   <= {1'b0, p_reg[63:32]};
                    qd_reg    <= p_reg[31:0];
                    cnt_reg   <= '0;
                    ret_reg   <= ST_RND_Y;
                    state_reg <= ST_DIV;
                end

                ST_RND_Y:
                begin
                    qy_reg    <= q_round;
                    cx_reg    <= step_coord(cx_reg, qx_reg, neg_x_reg);
                    a_reg     <= {33'd0, qx_reg};
                    p_reg     <= PROD_W'(qx_reg);
                    cnt_reg   <= '0;
                    ret_reg   <= ST_SQ_X;
                    state_reg <= ST_MUL;
                end

                ST_SQ_X:
                begin
                    sq_reg    <= p_reg[63:0];
                    cy_reg    <= step_coord(cy_reg, qy_reg, neg_y_reg);
                    a_reg     <= {33'd0, qy_reg};
                    p_reg     <= PROD_W'(qy_reg);
                    cnt_reg   <= '0;
                    ret_reg   <= ST_SUM_W1;
                    state_reg <= ST_MUL;
                end

                // shift term of the old mass, weighted by the old area
                ST_SUM_W1:
                begin
                    a_reg     <= sq_sum;
                    p_reg     <= PROD_W'(area_reg);
                    cnt_reg   <= '0;
                    ret_reg   <= ST_TERM1;
                    state_reg <= ST_MUL;
                end

                ST_TERM1:
                begin
                    term_reg  <= term_next;
                    state_reg <= ST_ADD_T1;
                end

                ST_ADD_T1:
                begin
                    inertia_reg <= sat_add64(inertia_reg, term_reg);
                    state_reg   <= ST_ADD_PI;
                end

                ST_ADD_PI:
                begin
                    inertia_reg <= sat_add64(inertia_reg, pi_reg);
                    a_reg       <= {33'd0, mag32(ex_cur)};
                    p_reg       <= PROD_W'(mag32(ex_cur));
                    cnt_reg     <= '0;
                    ret_reg     <= ST_SQ_EX;
                    state_reg   <= ST_MUL;
                end

                ST_SQ_EX:
                begin
                    sq_reg    <= p_reg[63:0];
                    a_reg     <= {33'd0, mag32(ey_cur)};
                    p_reg     <= PROD_W'(mag32(ey_cur));
                    cnt_reg   <= '0;
                    ret_reg   <= ST_SUM_W2;
                    state_reg <= ST_MUL;
                end

                // part's own offset from the new centroid
                ST_SUM_W2:
                begin
                    a_reg     <= sq_sum;
                    p_reg     <= PROD_W'(pa_reg);
                    cnt_reg   <= '0;
                    ret_reg   <= ST_TERM2;
                    state_reg <= ST_MUL;
                end

                ST_TERM2:
                begin
                    term_reg  <= term_next;
                    state_reg <= ST_ADD_T2;
                end

                ST_ADD_T2:
                begin
                    inertia_reg <= sat_add64(inertia_reg, term_reg);
                    area_reg    <= sum_reg[32] ? {32{1'b1}} : sum_reg[31:0];
                    state_reg   <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || body.ready)
                    begin
                        out_reg.body_kind     <= kind_reg;
                        out_reg.body_center_x <= cx_reg;
                        out_reg.body_center_y <= cy_reg;
                        out_reg.body_area     <= area_reg;
                        out_reg.body_inertia  <= inertia_reg;
                        out_reg.part_dropped  <= dropped_reg;
                        out_reg.last_result   <= last_reg;
                        out_valid_reg         <= 1'b1;
                        if (last_reg)
                        begin
                            kind_reg    <= BODY_NOTHING;
                            cx_reg      <= '0;
                            cy_reg      <= '0;
                            area_reg    <= '0;
                            inertia_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign part.ready   = (state_reg == ST_IDLE);
    assign body.valid   = out_valid_reg;
    assign body.payload = out_reg;

    a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sum_reg != '0) |-> (rem_reg < sum_reg))
        else $error("divider remainder not below area sum");

    a_dropped_keeps_inertia: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && dropped_reg) |-> $stable(inertia_reg))
        else $error("dropped part changed inertia");

    a_kind_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg <= BODY_UNKNOWN)
        else $error("body kind out of range");

endmodule
